// ===== design/mtwq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtwq_pkg;

  localparam int KIND_W = 2;
  localparam int ID_W   = 4;
  localparam int PID_W  = 8;
  localparam int VAL_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_LOCK   = 2'd2,
    KIND_UNLOCK = 2'd3
  } kind_t;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [PID_W-1:0] pid_t;
  typedef logic [VAL_W-1:0] val_t;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    kind_t kind;
    id_t   mutex_id;
    pid_t  pid;
    logic  in_range;
  } req_t;

  typedef struct packed {
    logic status;
    val_t result_value;
    logic blocked;
    logic woken_valid;
    pid_t woken_pid;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/mtwq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mtwq_req_if;
  logic              valid;
  logic              ready;
  mtwq_pkg::kind_t   kind;
  mtwq_pkg::id_t     mutex_id;
  mtwq_pkg::pid_t    requester_pid;

  modport source (output valid, output kind, output mutex_id, output requester_pid,
                  input ready);
  modport sink   (input valid, input kind, input mutex_id, input requester_pid,
                  output ready);
endinterface

interface mtwq_rsp_if;
  logic              valid;
  logic              ready;
  logic              status;
  mtwq_pkg::val_t    result_value;
  logic              blocked;
  logic              woken_valid;
  mtwq_pkg::pid_t    woken_pid;

  modport source (output valid, output status, output result_value, output blocked,
                  output woken_valid, output woken_pid, input ready);
  modport sink   (input valid, input status, input result_value, input blocked,
                  input woken_valid, input woken_pid, output ready);
endinterface

`default_nettype wire

// ===== design/mtwq_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtwq_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  mtwq_pkg::req_t      push_data,
  output logic                not_full,
  input  wire logic           pop,
  output logic                not_empty,
  output mtwq_pkg::req_t      pop_data
);

  mtwq_pkg::req_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign not_full  = (fill != 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/mtwq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtwq_front #(
  parameter int NUM_MUTEXES = 16,
  parameter int PID_BITS    = 8
) (
  mtwq_req_if.sink            req,
  output logic                push,
  output mtwq_pkg::req_t      push_data,
  input  wire logic           not_full
);

  mtwq_pkg::pid_t pid_mask;

  always_comb begin
    for (int i = 0; i < mtwq_pkg::PID_W; i++) begin
      pid_mask[i] = (i < PID_BITS);
    end
  end

  assign req.ready = not_full;
  assign push      = req.valid && not_full;

  // Classify: range check of the target id, trim the pid to its used bits.
  always_comb begin
    push_data.kind     = req.kind;
    push_data.mutex_id = req.mutex_id;
    push_data.pid      = req.requester_pid & pid_mask;
    push_data.in_range = (32'(req.mutex_id) < NUM_MUTEXES);
  end

endmodule

`default_nettype wire

// ===== design/mtwq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtwq_back #(
  parameter int NUM_MUTEXES = 16,
  parameter int WAIT_DEPTH  = 16,
  parameter int PID_BITS    = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           not_empty,
  input  mtwq_pkg::req_t      pop_data,
  output logic                pop,
  mtwq_rsp_if.source          rsp
);

  localparam int IW  = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam int FCW = $clog2(NUM_MUTEXES + 1);
  localparam int QW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int QCW = $clog2(WAIT_DEPTH + 1);
  localparam int CW  = $clog2(WAIT_DEPTH + 2);
  localparam int PW  = (PID_BITS < mtwq_pkg::PID_W) ? PID_BITS : mtwq_pkg::PID_W;
  localparam int AW  = $clog2(NUM_MUTEXES * WAIT_DEPTH);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t          state;
  mtwq_pkg::req_t  r;
  logic [IW-1:0]   t;

  logic [IW-1:0]   fifo   [NUM_MUTEXES];
  logic [IW-1:0]   fhead;
  logic [FCW-1:0]  fcnt;
  logic [CW-1:0]   cnt    [NUM_MUTEXES];
  logic [PW-1:0]   owner  [NUM_MUTEXES];
  logic [QW-1:0]   qhead  [NUM_MUTEXES];
  logic [QCW-1:0]  qcnt   [NUM_MUTEXES];

  logic [PW-1:0]   wait_mem [NUM_MUTEXES * WAIT_DEPTH];
  logic [PW-1:0]   wrd;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;

  logic            out_valid;
  mtwq_pkg::rsp_t  out;

  logic [IW-1:0]   q_idx;
  logic [IW-1:0]   tgt;

  logic [CW-1:0]   c;
  logic [QW-1:0]   h;
  logic [QCW-1:0]  n;
  logic [PW-1:0]   pidm;
  logic [QW-1:0]   tail_slot;
  logic [QW-1:0]   head_next;
  logic [IW-1:0]   ftail;
  logic [IW-1:0]   fhead_next;
  int              sum;

  logic do_alloc, do_free, do_lock_new, do_enqueue, do_unlock_last, do_handoff;
  mtwq_pkg::rsp_t  res;

  // Front end of the back: pick the target entry and start the wait read.
  assign pop   = (state == ST_IDLE) && not_empty && (!out_valid || rsp.ready);
  assign q_idx = IW'(pop_data.mutex_id);
  assign tgt   = (pop_data.kind == mtwq_pkg::KIND_ALLOC) ? fifo[fhead] : q_idx;
  assign raddr = AW'(32'(tgt) * WAIT_DEPTH + 32'(qhead[tgt]));

  always_comb begin
    c    = cnt[t];
    h    = qhead[t];
    n    = qcnt[t];
    pidm = r.pid[PW-1:0];

    sum       = 32'(h) + 32'(n);
    tail_slot = (sum >= WAIT_DEPTH) ? QW'(sum - WAIT_DEPTH) : QW'(sum);
    head_next = (32'(h) + 1 >= WAIT_DEPTH) ? '0 : h + QW'(1);
    ftail     = (32'(fhead) + 32'(fcnt) >= NUM_MUTEXES)
              ? IW'(32'(fhead) + 32'(fcnt) - NUM_MUTEXES)
              : IW'(32'(fhead) + 32'(fcnt));
    fhead_next = (32'(fhead) + 1 >= NUM_MUTEXES) ? '0 : fhead + IW'(1);
    waddr      = AW'(32'(t) * WAIT_DEPTH + 32'(tail_slot));

    do_alloc       = 1'b0;
    do_free        = 1'b0;
    do_lock_new    = 1'b0;
    do_enqueue     = 1'b0;
    do_unlock_last = 1'b0;
    do_handoff     = 1'b0;
    res            = '0;
    res.status     = 1'b1;

    case (r.kind)
      mtwq_pkg::KIND_ALLOC: begin
        if (fcnt != '0) begin
          do_alloc         = 1'b1;
          res.status       = 1'b0;
          res.result_value = mtwq_pkg::val_t'(t);
        end
      end
      mtwq_pkg::KIND_FREE: begin
        if (r.in_range && c == '0 && 32'(fcnt) < NUM_MUTEXES) begin
          do_free    = 1'b1;
          res.status = 1'b0;
        end
      end
      mtwq_pkg::KIND_LOCK: begin
        if (r.in_range) begin
          if (c != '0) begin
            if (32'(n) < WAIT_DEPTH) begin
              do_enqueue       = 1'b1;
              res.status       = 1'b0;
              res.blocked      = 1'b1;
              res.result_value = mtwq_pkg::val_t'(c);
            end
          end else begin
            do_lock_new = 1'b1;
            res.status  = 1'b0;
          end
        end
      end
      mtwq_pkg::KIND_UNLOCK: begin
        if (r.in_range) begin
          if (c == '0) begin
            res.status = 1'b0;
          end else if (owner[t] == pidm) begin
            if (c == CW'(1)) begin
              do_unlock_last = 1'b1;
              res.status     = 1'b0;
            end else if (n != '0) begin
              do_handoff       = 1'b1;
              res.status       = 1'b0;
              res.woken_valid  = 1'b1;
              res.woken_pid    = mtwq_pkg::pid_t'(wrd);
              res.result_value = mtwq_pkg::val_t'(c - CW'(1));
            end
          end
        end
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      fhead     <= '0;
      fcnt      <= FCW'(NUM_MUTEXES);
      for (int i = 0; i < NUM_MUTEXES; i++) begin
        fifo[i]  <= IW'(i);
        cnt[i]   <= '0;
        qhead[i] <= '0;
        qcnt[i]  <= '0;
      end
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            r     <= pop_data;
            t     <= tgt;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid <= 1'b1;
          out       <= res;
          state     <= ST_IDLE;
          if (do_alloc) begin
            fhead    <= fhead_next;
            fcnt     <= fcnt - FCW'(1);
            cnt[t]   <= '0;
            qhead[t] <= '0;
            qcnt[t]  <= '0;
          end
          if (do_free) begin
            fifo[ftail] <= t;
            fcnt        <= fcnt + FCW'(1);
            cnt[t]      <= '0;
            qhead[t]    <= '0;
            qcnt[t]     <= '0;
          end
          if (do_lock_new) begin
            owner[t] <= pidm;
            cnt[t]   <= CW'(1);
          end
          if (do_enqueue) begin
            qcnt[t] <= n + QCW'(1);
            cnt[t]  <= c + CW'(1);
          end
          if (do_unlock_last) begin
            cnt[t] <= '0;
          end
          if (do_handoff) begin
            qhead[t] <= head_next;
            qcnt[t]  <= n - QCW'(1);
            cnt[t]   <= c - CW'(1);
            owner[t] <= wrd;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC && do_enqueue) begin
      wait_mem[waddr] <= pidm;
    end
    wrd <= wait_mem[raddr];
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out.status;
  assign rsp.result_value = out.result_value;
  assign rsp.blocked      = out.blocked;
  assign rsp.woken_valid  = out.woken_valid;
  assign rsp.woken_pid    = out.woken_pid;

endmodule

`default_nettype wire

// ===== design/mutex_table_with_wait_queues.sv =====
// Channel  Direction  Interface    Payload
// req      in         mtwq_req_if  kind, mutex_id, requester_pid
// rsp      out        mtwq_rsp_if  status, result_value, blocked, woken_valid, woken_pid
//
// In the back end, each request first picks its target entry and reads the head of
// its wait queue from the wait memory (ST_IDLE), then updates the entry (ST_EXEC).
// Its response is held in the output register; the back end pops a new request only
// in ST_IDLE with that register empty or being taken, so never before the last is done.
// Synchronous reset empties the request queue and output register, fills the free
// id list with every id in order and clears all lock counts and wait queues.
// A stalled rsp holds its transaction and the back end stops popping; req stays
// ready until two more transactions wait in the request queue, then drops.
`timescale 1ns / 1ps
`default_nettype none

module mutex_table_with_wait_queues #(
  parameter int NUM_MUTEXES = 16,
  parameter int WAIT_DEPTH  = 16,
  parameter int PID_BITS    = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mtwq_req_if.sink   req,
  mtwq_rsp_if.source rsp
);

  logic           push;
  logic           not_full;
  logic           pop;
  logic           not_empty;
  mtwq_pkg::req_t push_data;
  mtwq_pkg::req_t pop_data;

  // Classify the transaction and hand it to the queue.
  mtwq_front #(
    .NUM_MUTEXES (NUM_MUTEXES),
    .PID_BITS    (PID_BITS)
  ) u_front (
    .req       (req),
    .push      (push),
    .push_data (push_data),
    .not_full  (not_full)
  );

  // Decouple the front from the back.
  mtwq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .not_full  (not_full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  // Carry out the operation against the mutex table.
  mtwq_back #(
    .NUM_MUTEXES (NUM_MUTEXES),
    .WAIT_DEPTH  (WAIT_DEPTH),
    .PID_BITS    (PID_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== design/mtwq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtwq_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire logic           status,
  input wire logic           blocked,
  input wire logic           woken_valid,
  input mtwq_pkg::pid_t      woken_pid
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(woken_pid))
    else $error("rsp dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

  a_block_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && blocked |-> !status && !woken_valid)
    else $error("blocked with error or wakeup");

  a_wake_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && woken_valid |-> !status)
    else $error("wakeup with error status");

  a_wake_pid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !woken_valid |-> woken_pid == '0)
    else $error("woken pid without wakeup");

endmodule

bind mutex_table_with_wait_queues mtwq_checker u_mtwq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .blocked     (rsp.blocked),
  .woken_valid (rsp.woken_valid),
  .woken_pid   (rsp.woken_pid)
);

`default_nettype wire
